// File: rtl/rfc3339_timestamp_parser_assert.svh
// Assertion helpers for the timestamp parser.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RFC3339_TIMESTAMP_PARSER_ASSERT_SVH
`define RFC3339_TIMESTAMP_PARSER_ASSERT_SVH

// Same-cycle implication, ignored during reset
`define RTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtp: same-cycle check failed");

// Next-cycle implication, ignored during reset
`define RTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtp: next-cycle check failed");

`endif

// File: rtl/rtp_pkg.sv
package rtp_pkg;

    // Field widths
    localparam int CH_W      = 8;
    localparam int YEAR_W    = 27;
    localparam int FIELD_W   = 10;
    localparam int SEC_W     = 7;
    localparam int USEC_W    = 20;
    localparam int OFF_W     = 23;
    localparam int ACC_W     = 27;
    localparam int CNT_W     = 4;
    localparam int DIGIT_W   = 4;
    localparam int BASE_W    = 16;
    localparam int MIN_W     = 7;
    localparam int FRAC_ACC_W = 17;
    localparam int FRAC_IDX_W = 3;

    // Result beat packing
    localparam int PAYLOAD_W = YEAR_W + 4 * FIELD_W + SEC_W + USEC_W + 1 + OFF_W;
    localparam int DATA_W    = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = DATA_W - PAYLOAD_W;

    // Limits
    localparam int YEAR_MAX_CHARS_DEF = 8;
    localparam int FIELD_MAX_CHARS    = 3;
    localparam int TWO_DIGITS         = 2;
    localparam int FRAC_DIGITS        = 6;
    localparam int QUEUE_DEPTH_DEF    = 2;

    // Characters
    localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CH_T     = 8'h54;
    localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_Z     = 8'h5A;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // Classified character, front to back
    typedef struct packed {
        logic               start;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_dash;
        logic               is_t;
        logic               is_colon;
        logic               is_dot;
        logic               is_z;
        logic               is_plus;
    } char_class_t;

    // One parse result
    typedef struct packed {
        logic               status;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [SEC_W-1:0]   second;
        logic [USEC_W-1:0]  usec;
        logic               has_frac;
        logic [OFF_W-1:0]   offset;
    } result_t;

    // Scale a fraction of n digits up to microseconds
    function automatic logic [USEC_W-1:0] pad_scale(input logic [FRAC_IDX_W-1:0] n);
        logic [USEC_W-1:0] s;
        begin
            case (n)
                3'd0:    s = 20'd1000000;
                3'd1:    s = 20'd100000;
                3'd2:    s = 20'd10000;
                3'd3:    s = 20'd1000;
                3'd4:    s = 20'd100;
                3'd5:    s = 20'd10;
                default: s = 20'd1;
            endcase
            return s;
        end
    endfunction

endpackage

// File: rtl/rtp_front.sv
module rtp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] ch
    input  logic                 s_tuser,   // [0] start_req
    output logic                 cls_valid,
    input  logic                 cls_ready,
    output rtp_pkg::char_class_t cls
);

    logic                 valid_reg;
    logic                 valid_next;
    rtp_pkg::char_class_t cls_reg;
    rtp_pkg::char_class_t cls_next;
    logic [rtp_pkg::CH_W-1:0] diff;
    logic                 load;

    // Classify the incoming character
    always_comb
    begin
        diff              = s_tdata - rtp_pkg::CH_ZERO;
        cls_next.start    = s_tuser;
        cls_next.is_digit = (s_tdata >= rtp_pkg::CH_ZERO) && (s_tdata <= rtp_pkg::CH_NINE);
        cls_next.digit    = cls_next.is_digit ? diff[rtp_pkg::DIGIT_W-1:0] : '0;
        cls_next.is_dash  = (s_tdata == rtp_pkg::CH_DASH);
        cls_next.is_t     = (s_tdata == rtp_pkg::CH_T);
        cls_next.is_colon = (s_tdata == rtp_pkg::CH_COLON);
        cls_next.is_dot   = (s_tdata == rtp_pkg::CH_DOT);
        cls_next.is_z     = (s_tdata == rtp_pkg::CH_Z);
        cls_next.is_plus  = (s_tdata == rtp_pkg::CH_PLUS);
    end

    // Take a beat whenever the stage is empty or draining
    assign s_tready  = !valid_reg || cls_ready;
    assign load      = s_tvalid && s_tready;
    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (cls_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the classified beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

// File: rtl/rtp_queue.sv
module rtp_queue #(
    parameter int DEPTH = rtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rtp_pkg::char_class_t in_item,
    output logic                 out_valid,
    input  logic                 out_pop,
    output rtp_pkg::char_class_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtp_pkg::char_class_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !out_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && out_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/rtp_back.sv
`include "rfc3339_timestamp_parser_assert.svh"

module rtp_back #(
    parameter int YEAR_MAX_CHARS = rtp_pkg::YEAR_MAX_CHARS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rtp_pkg::char_class_t q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rtp_pkg::result_t     res
);

    typedef enum logic [3:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SEC,
        PH_AFTER_SEC,
        PH_FRAC,
        PH_ZONE,
        PH_OFF_HOUR,
        PH_OFF_MIN,
        PH_DONE
    } phase_t;

    localparam int ACC_W   = rtp_pkg::ACC_W;
    localparam int CNT_W   = rtp_pkg::CNT_W;
    localparam int FIELD_W = rtp_pkg::FIELD_W;
    localparam int BASE_W  = rtp_pkg::BASE_W;
    localparam int OFF_W   = rtp_pkg::OFF_W;
    localparam int USEC_W  = rtp_pkg::USEC_W;

    phase_t                      phase_reg, phase_next, ph_cur;
    logic [ACC_W-1:0]            acc_reg, acc_next, acc_cur, acc_upd;
    logic [CNT_W-1:0]            cnt_reg, cnt_next, cnt_cur, cnt_upd;
    logic [rtp_pkg::YEAR_W-1:0]  year_reg, year_next, year_cur;
    logic [FIELD_W-1:0]          month_reg, month_next, month_cur;
    logic [FIELD_W-1:0]          day_reg, day_next, day_cur;
    logic [FIELD_W-1:0]          hour_reg, hour_next, hour_cur;
    logic [FIELD_W-1:0]          minute_reg, minute_next, minute_cur;
    logic [rtp_pkg::SEC_W-1:0]   sec_reg, sec_next, sec_cur;
    logic [USEC_W-1:0]           frac_reg, frac_next, frac_cur;
    logic                        fseen_reg, fseen_next, fseen_cur;
    logic                        neg_reg, neg_next, neg_cur;
    logic [BASE_W-1:0]           base_reg, base_next, base_cur;
    logic                        out_valid_reg, out_valid_next;
    rtp_pkg::result_t            res_reg, res_next;

    logic                        take;
    logic                        emit_ok, emit_err;
    logic                        zone;
    logic                        field_end;
    logic [ACC_W-1:0]            field_val;
    logic                        stop;
    logic [CNT_W-1:0]            max_chars;
    logic [36:0]                 frac_prod;
    logic [BASE_W:0]             off_sum;
    logic [OFF_W-1:0]            off_total;
    logic [OFF_W-1:0]            off_val;

    assign take      = q_valid && (!out_valid_reg || res_ready);
    assign q_pop     = take;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Start of a timestamp clears the working state
    always_comb
    begin
        if (q_item.start)
        begin
            ph_cur     = PH_YEAR;
            acc_cur    = '0;
            cnt_cur    = '0;
            year_cur   = '0;
            month_cur  = '0;
            day_cur    = '0;
            hour_cur   = '0;
            minute_cur = '0;
            sec_cur    = '0;
            frac_cur   = '0;
            fseen_cur  = 1'b0;
            neg_cur    = 1'b0;
            base_cur   = '0;
        end
        else
        begin
            ph_cur     = phase_reg;
            acc_cur    = acc_reg;
            cnt_cur    = cnt_reg;
            year_cur   = year_reg;
            month_cur  = month_reg;
            day_cur    = day_reg;
            hour_cur   = hour_reg;
            minute_cur = minute_reg;
            sec_cur    = sec_reg;
            frac_cur   = frac_reg;
            fseen_cur  = fseen_reg;
            neg_cur    = neg_reg;
            base_cur   = base_reg;
        end
    end

    // Shared datapath: times-ten accumulate, field limits, delimiters, fraction padding, offset total
    always_comb
    begin
        acc_upd   = ACC_W'((acc_cur << 3) + (acc_cur << 1) + ACC_W'(q_item.digit));
        cnt_upd   = cnt_cur + 1'b1;
        max_chars = (ph_cur == PH_YEAR) ? CNT_W'(YEAR_MAX_CHARS)
                                        : CNT_W'(rtp_pkg::FIELD_MAX_CHARS);
        case (ph_cur)
            PH_YEAR, PH_MONTH: stop = q_item.is_dash;
            PH_DAY:            stop = q_item.is_t;
            default:           stop = q_item.is_colon;
        endcase
        frac_prod = acc_cur[rtp_pkg::FRAC_ACC_W-1:0]
                    * rtp_pkg::pad_scale(cnt_cur[rtp_pkg::FRAC_IDX_W-1:0]);
        off_sum   = (BASE_W + 1)'(base_cur) + (BASE_W + 1)'(acc_upd[rtp_pkg::MIN_W-1:0]);
        off_total = OFF_W'((OFF_W'(off_sum) << 6) - (OFF_W'(off_sum) << 2));
    end

    // Phase step for one character
    always_comb
    begin
        phase_next  = ph_cur;
        acc_next    = acc_cur;
        cnt_next    = cnt_cur;
        year_next   = year_cur;
        month_next  = month_cur;
        day_next    = day_cur;
        hour_next   = hour_cur;
        minute_next = minute_cur;
        sec_next    = sec_cur;
        frac_next   = frac_cur;
        fseen_next  = fseen_cur;
        neg_next    = neg_cur;
        base_next   = base_cur;
        emit_ok     = 1'b0;
        emit_err    = 1'b0;
        zone        = 1'b0;
        field_end   = 1'b0;
        field_val   = acc_cur;
        off_val     = '0;

        case (ph_cur)
            PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_OFF_HOUR:
            begin
                if (q_item.is_digit)
                begin
                    acc_next = acc_upd;
                    cnt_next = cnt_upd;
                    if (cnt_upd >= max_chars)
                    begin
                        field_end = 1'b1;
                        field_val = acc_upd;
                    end
                end
                else if (stop)
                begin
                    field_end = 1'b1;
                end
                else
                begin
                    emit_err = 1'b1;
                end
            end
            PH_SEC:
            begin
                if (!q_item.is_digit)
                begin
                    emit_err = 1'b1;
                end
                else if (cnt_upd >= CNT_W'(rtp_pkg::TWO_DIGITS))
                begin
                    sec_next   = acc_upd[rtp_pkg::SEC_W-1:0];
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_AFTER_SEC;
                end
                else
                begin
                    acc_next = acc_upd;
                    cnt_next = cnt_upd;
                end
            end
            PH_AFTER_SEC:
            begin
                if (q_item.is_dot)
                begin
                    fseen_next = 1'b1;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_FRAC;
                end
                else
                begin
                    zone = 1'b1;
                end
            end
            PH_FRAC:
            begin
                if (q_item.is_digit)
                begin
                    acc_next = acc_upd;
                    cnt_next = cnt_upd;
                    if (cnt_upd >= CNT_W'(rtp_pkg::FRAC_DIGITS))
                    begin
                        frac_next  = acc_upd[USEC_W-1:0];
                        phase_next = PH_ZONE;
                    end
                end
                else
                begin
                    frac_next = frac_prod[USEC_W-1:0];
                    zone      = 1'b1;
                end
            end
            PH_ZONE:
            begin
                zone = 1'b1;
            end
            PH_OFF_MIN:
            begin
                if (!q_item.is_digit)
                begin
                    emit_err = 1'b1;
                end
                else
                begin
                    acc_next = acc_upd;
                    cnt_next = cnt_upd;
                    if (cnt_upd >= CNT_W'(rtp_pkg::TWO_DIGITS))
                    begin
                        emit_ok = 1'b1;
                        off_val = neg_cur ? OFF_W'(-off_total) : off_total;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Zone designator: Z ends the parse, a sign opens the offset
        if (zone)
        begin
            if (q_item.is_z)
            begin
                neg_next = 1'b0;
                emit_ok  = 1'b1;
            end
            else if (q_item.is_dash || q_item.is_plus)
            begin
                neg_next   = q_item.is_dash;
                acc_next   = '0;
                cnt_next   = '0;
                phase_next = PH_OFF_HOUR;
            end
            else
            begin
                emit_err = 1'b1;
            end
        end

        // Close a field (delimiter or full width) and move on
        if (field_end)
        begin
            acc_next = '0;
            cnt_next = '0;
            case (ph_cur)
                PH_YEAR:
                begin
                    year_next  = field_val;
                    phase_next = PH_MONTH;
                end
                PH_MONTH:
                begin
                    month_next = field_val[FIELD_W-1:0];
                    phase_next = PH_DAY;
                end
                PH_DAY:
                begin
                    day_next   = field_val[FIELD_W-1:0];
                    phase_next = PH_HOUR;
                end
                PH_HOUR:
                begin
                    hour_next  = field_val[FIELD_W-1:0];
                    phase_next = PH_MINUTE;
                end
                PH_MINUTE:
                begin
                    minute_next = field_val[FIELD_W-1:0];
                    phase_next  = PH_SEC;
                end
                default:
                begin
                    // offset hours kept as minutes: h * 64 - h * 4
                    base_next  = BASE_W'((BASE_W'(field_val[FIELD_W-1:0]) << 6)
                                         - (BASE_W'(field_val[FIELD_W-1:0]) << 2));
                    phase_next = PH_OFF_MIN;
                end
            endcase
        end

        if (emit_ok || emit_err)
        begin
            phase_next = PH_DONE;
        end
    end

    // Result register: load on a finishing beat, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        if (take && emit_err)
        begin
            out_valid_next  = 1'b1;
            res_next        = '0;
            res_next.status = 1'b1;
        end
        else if (take && emit_ok)
        begin
            out_valid_next    = 1'b1;
            res_next.status   = 1'b0;
            res_next.year     = year_next;
            res_next.month    = month_next;
            res_next.day      = day_next;
            res_next.hour     = hour_next;
            res_next.minute   = minute_next;
            res_next.second   = sec_next;
            res_next.usec     = frac_next;
            res_next.has_frac = fseen_next;
            res_next.offset   = off_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            sec_reg       <= '0;
            frac_reg      <= '0;
            fseen_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                cnt_reg    <= cnt_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                sec_reg    <= sec_next;
                frac_reg   <= frac_next;
                fseen_reg  <= fseen_next;
                neg_reg    <= neg_next;
                base_reg   <= base_next;
            end
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    `RTP_ASSERT_NXT(a_done_after_result, take && (emit_ok || emit_err), phase_reg == PH_DONE)
    `RTP_ASSERT_IMP(a_idle_silent, take && !q_item.start && phase_reg == PH_DONE, !emit_ok && !emit_err)
    `RTP_ASSERT_IMP(a_err_clean, out_valid_reg && res_reg.status, res_reg.year == '0 && res_reg.offset == '0 && !res_reg.has_frac)
    `RTP_ASSERT_IMP(a_two_digit_cnt, phase_reg == PH_SEC || phase_reg == PH_OFF_MIN, cnt_reg < CNT_W'(rtp_pkg::TWO_DIGITS))

endmodule

// File: rtl/rfc3339_timestamp_parser.sv
// RFC 3339 timestamp parser. Characters arrive one per beat on the slave side;
// s_tuser marks the first character of a timestamp and restarts the parse.
// One result beat leaves on the master side when the text completes (status 0)
// or hits an unexpected character (status 1, all other fields zero); characters
// after that are dropped until the next start. A new character is taken every
// clock cycle while no result waits on m_tready: the parse keeps one character
// per cycle through a times-ten accumulate loop in the back end. The character
// that ends the timestamp passes the classifier register, the queue (two entries
// by default) and the parse step into the result register.
module rfc3339_timestamp_parser #(
    parameter int YEAR_MAX_CHARS = rtp_pkg::YEAR_MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH    = rtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,  // [7:0] ch
    input  logic                       s_tuser,  // [0] start_req
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [26:0] year, [36:27] month, [46:37] day, [56:47] hour, [66:57] minute,
    // [73:67] second, [93:74] microseconds, [94] has_fraction,
    // [117:95] offset_seconds, [119:118] zero
    output logic [rtp_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tuser   // [0] status
);

    rtp_pkg::char_class_t cls;
    rtp_pkg::char_class_t q_item;
    rtp_pkg::result_t     res;
    logic                 cls_valid, cls_ready;
    logic                 q_valid, q_pop;

    rtp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls       (cls)
    );

    rtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_item   (cls),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    rtp_back #(
        .YEAR_MAX_CHARS (YEAR_MAX_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_tuser = res.status;
    assign m_tdata = {{rtp_pkg::PAD_W{1'b0}}, res.offset, res.has_frac, res.usec, res.second,
                      res.minute, res.hour, res.day, res.month, res.year};

endmodule
